@@ hw/rtl/bthau_pkg.sv @@
`timescale 1ns / 1ps

package bthau_pkg;

  // Heap geometry.
  localparam int HEAP_UNITS    = 1024;
  localparam int GRANULE_BYTES = 16;
  localparam int GRAN_SHIFT    = $clog2(GRANULE_BYTES);
  localparam int IDX_W         = $clog2(HEAP_UNITS);
  localparam int CNT_W         = 11;
  localparam int ADDR_W        = 13;
  localparam int MIN_UNITS     = 4;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_MEM   = 2'd1;
  localparam logic [1:0] ST_NULL_PTR = 2'd2;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;

  // One granule of the heap store: header or footer word.
  typedef struct packed {
    logic             tag;
    logic [CNT_W-1:0] size;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } heap_entry_t;

  localparam int ENTRY_W = $bits(heap_entry_t);

  typedef struct packed {
    logic        kind;
    logic [13:0] request_bytes;
    logic [9:0]  block_address;
  } bthau_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [9:0]       granted_address;
    logic [CNT_W-1:0] in_use_units;
    logic [CNT_W-1:0] peak_units;
  } bthau_res_t;

  typedef enum logic [5:0] {
    S_FMT_CLR, S_FMT_HEAD, S_FMT_FOOT, S_FMT_SENT,
    S_IDLE,
    S_A_WALK, S_A_W_LNK1, S_A_W_LNK2, S_A_W_TAGP, S_A_W_TAGF,
    S_A_S_TAGF, S_A_S_SIZE, S_A_S_FOOT, S_A_S_HEAD, S_A_FIN,
    S_F_HDR, S_F_LT, S_F_RT,
    S_F11_TAGP, S_F11_F, S_F11_SELF, S_F11_Q, S_F11_PL, S_F11_RL, S_F11_QR,
    S_F01_S, S_F01_F,
    S_F10_TAGP, S_F10_A, S_F10_B, S_F10_C, S_F10_D, S_F10_E, S_F10_F,
    S_F10_G, S_F10_H, S_F10_I, S_F10_J, S_F10_K, S_F10_L,
    S_F00_TS, S_F00_S, S_F00_A, S_F00_B, S_F00_C, S_F00_D, S_F00_E, S_F00_F
  } bthau_state_t;

endpackage

@@ hw/rtl/bthau_ram.sv @@
`timescale 1ns / 1ps

module bthau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Simple dual-port array with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/boundary_tag_heap_allocator_unit.sv @@
`timescale 1ns / 1ps

// Boundary-tag heap allocator with a next-fit roving free-list head.
// A request is taken when start is high and busy is low. An allocate
// request asks for request_bytes and gets a payload granule index; a free
// request returns the block at block_address. Every request produces one
// result on out_res, marked by out_valid for exactly one cycle; the
// receiver cannot stall it.
// Each request is a sequence of single-granule read-modify-write steps on
// the heap memory, one access per cycle. After acceptance busy stays high
// while the walk visits free blocks and the allocate or free steps run.
// A null free, a free outside the heap and an allocate with an empty free
// list keep busy low. The result appears in the first cycle with busy low,
// when the next request may already be taken. Rate is set by the single
// read port of the memory. After reset, and after every cfg_we write of
// heap_units, the heap is formatted with busy high: every granule is
// cleared, then header, footer and sentinel are written. The used count
// and its peak are cleared then. The user must write configuration only
// while no request is in flight; the block itself does not enforce this.

module boundary_tag_heap_allocator_unit
  import bthau_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  bthau_req_t       in_req,
  output logic             out_valid,
  output bthau_res_t       out_res,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  bthau_state_t     state_r, state_nxt;
  addr_t            ma_r, ma_nxt;
  logic             oob_r;
  logic             fwd_r;
  heap_entry_t      fwd_q_r;
  addr_t            p_r, p_nxt, f_r, f_nxt, s_r, s_nxt, t_r, t_nxt;
  logic [IDX_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [CNT_W-1:0] size_r, size_nxt, sz_r, sz_nxt, units_r, units_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] rover_r, rover_nxt;
  logic             rv_r, rv_nxt;
  logic [CNT_W-1:0] used_r, used_nxt, peak_r, peak_nxt;
  logic [CNT_W-1:0] limit_r, limit_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic             out_valid_r, out_valid_nxt;
  bthau_res_t       out_res_r, out_res_nxt;

  addr_t            rd_a;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  heap_entry_t      wr_data;
  heap_entry_t      ram_q;
  heap_entry_t      cur;
  heap_entry_t      w;
  logic             emit;
  logic [1:0]       emit_status;
  logic [9:0]       emit_granted;
  logic [CNT_W:0]   used_sum;
  logic [CNT_W-1:0] cfg_limit;
  logic [14:0]      bytes_up;

  bthau_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_UNITS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_a[IDX_W-1:0]),
    .rdata (ram_q)
  );

  // Granules outside the heap read as allocated, size zero, null links.
  always_comb begin
    if (oob_r) begin
      cur = '{tag: 1'b1, size: '0, left: '0, right: '0};
    end else if (fwd_r) begin
      cur = fwd_q_r;
    end else begin
      cur = ram_q;
    end
  end

  // Saturated heap size from a configuration write.
  always_comb begin
    if (cfg_wdata < CNT_W'(MIN_UNITS)) begin
      cfg_limit = CNT_W'(MIN_UNITS);
    end else if (cfg_wdata > CNT_W'(HEAP_UNITS)) begin
      cfg_limit = CNT_W'(HEAP_UNITS);
    end else begin
      cfg_limit = cfg_wdata;
    end
  end

  assign bytes_up = {1'b0, in_req.request_bytes} + 15'(GRANULE_BYTES - 1);

  // Sequencer: each step consumes the granule read in the previous cycle,
  // may write it back modified, and issues the next read.
  always_comb begin
    state_nxt    = state_r;
    ma_nxt       = ma_r;
    p_nxt        = p_r;
    f_nxt        = f_r;
    s_nxt        = s_r;
    t_nxt        = t_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    size_nxt     = size_r;
    sz_nxt       = sz_r;
    units_nxt    = units_r;
    n_nxt        = n_r;
    rover_nxt    = rover_r;
    rv_nxt       = rv_r;
    used_nxt     = used_r;
    peak_nxt     = peak_r;
    limit_nxt    = limit_r;
    clr_nxt      = clr_r;
    rd_a         = ma_r;
    wr_en        = 1'b0;
    wr_addr      = ma_r[IDX_W-1:0];
    w            = cur;
    emit         = 1'b0;
    emit_status  = ST_OK;
    emit_granted = '0;
    used_sum     = '0;

    unique case (state_r)
      S_FMT_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        w       = '0;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_FMT_HEAD;
        end
      end
      S_FMT_HEAD: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        w         = '0;
        w.size    = limit_r - CNT_W'(1);
        state_nxt = S_FMT_FOOT;
      end
      S_FMT_FOOT: begin
        wr_en     = 1'b1;
        wr_addr   = IDX_W'(limit_r - CNT_W'(2));
        w         = '0;
        state_nxt = S_FMT_SENT;
      end
      S_FMT_SENT: begin
        wr_en     = 1'b1;
        wr_addr   = IDX_W'(limit_r - CNT_W'(1));
        w         = '0;
        w.tag     = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (in_req.kind == KIND_ALLOC) begin
            units_nxt = CNT_W'(bytes_up >> GRAN_SHIFT) + CNT_W'(2);
            if (!rv_r) begin
              emit        = 1'b1;
              emit_status = ST_NO_MEM;
            end else begin
              p_nxt     = addr_t'(rover_r);
              n_nxt     = '0;
              rd_a      = addr_t'(rover_r);
              state_nxt = S_A_WALK;
            end
          end else if (in_req.block_address == '0) begin
            emit        = 1'b1;
            emit_status = ST_NULL_PTR;
          end else if (CNT_W'(in_req.block_address - 10'd1) < limit_r) begin
            p_nxt     = addr_t'(in_req.block_address - 10'd1);
            rd_a      = addr_t'(in_req.block_address - 10'd1);
            state_nxt = S_F_HDR;
          end else begin
            emit = 1'b1;
          end
        end
      end

      // Next-fit walk from the rover.
      S_A_WALK: begin
        if (cur.size < units_r && cur.right != rover_r && n_r < limit_r) begin
          p_nxt = addr_t'(cur.right);
          n_nxt = n_r + CNT_W'(1);
          rd_a  = addr_t'(cur.right);
        end else if (cur.size < units_r) begin
          emit        = 1'b1;
          emit_status = ST_NO_MEM;
          state_nxt   = S_IDLE;
        end else begin
          sz_nxt    = cur.size;
          x_nxt     = cur.left;
          rover_nxt = cur.right;
          f_nxt     = p_r + addr_t'(cur.size) - addr_t'(1);
          if (cur.size - units_r <= CNT_W'(1)) begin
            if (addr_t'(cur.right) == p_r) begin
              rv_nxt    = 1'b0;
              rd_a      = p_r;
              state_nxt = S_A_W_TAGP;
            end else begin
              rd_a      = addr_t'(cur.right);
              state_nxt = S_A_W_LNK1;
            end
          end else begin
            rd_a      = p_r + addr_t'(cur.size) - addr_t'(1);
            state_nxt = S_A_S_TAGF;
          end
        end
      end
      // Whole block: unlink it from the free list.
      S_A_W_LNK1: begin
        wr_en     = !oob_r;
        w.left    = x_r;
        rd_a      = addr_t'(x_r);
        state_nxt = S_A_W_LNK2;
      end
      S_A_W_LNK2: begin
        wr_en     = !oob_r;
        w.right   = rover_r;
        rd_a      = p_r;
        state_nxt = S_A_W_TAGP;
      end
      S_A_W_TAGP: begin
        wr_en     = !oob_r;
        w.tag     = 1'b1;
        rd_a      = f_r;
        state_nxt = S_A_W_TAGF;
      end
      S_A_W_TAGF: begin
        wr_en     = !oob_r;
        w.tag     = 1'b1;
        rd_a      = p_r;
        state_nxt = S_A_FIN;
      end
      // Split: cut the upper part off the free block.
      S_A_S_TAGF: begin
        wr_en     = !oob_r;
        w.tag     = 1'b1;
        rd_a      = p_r;
        state_nxt = S_A_S_SIZE;
      end
      S_A_S_SIZE: begin
        wr_en     = !oob_r;
        w.size    = sz_r - units_r;
        f_nxt     = p_r + addr_t'(sz_r - units_r) - addr_t'(1);
        rd_a      = p_r + addr_t'(sz_r - units_r) - addr_t'(1);
        state_nxt = S_A_S_FOOT;
      end
      S_A_S_FOOT: begin
        wr_en     = !oob_r;
        w.tag     = 1'b0;
        w.left    = p_r[IDX_W-1:0];
        p_nxt     = f_r + addr_t'(1);
        rd_a      = f_r + addr_t'(1);
        state_nxt = S_A_S_HEAD;
      end
      S_A_S_HEAD: begin
        wr_en     = !oob_r;
        w.tag     = 1'b1;
        w.size    = units_r;
        rd_a      = p_r;
        state_nxt = S_A_FIN;
      end
      // Account for the granted block.
      S_A_FIN: begin
        used_sum = {1'b0, used_r} + {1'b0, cur.size};
        used_nxt = used_sum[CNT_W] ? '1 : used_sum[CNT_W-1:0];
        if (used_nxt > peak_r) begin
          peak_nxt = used_nxt;
        end
        emit         = 1'b1;
        emit_granted = 10'(p_r + addr_t'(1));
        state_nxt    = S_IDLE;
      end

      // Free: header, left neighbour's footer, right neighbour's header.
      S_F_HDR: begin
        size_nxt  = cur.size;
        f_nxt     = p_r + addr_t'(cur.size) - addr_t'(1);
        rd_a      = p_r - addr_t'(1);
        state_nxt = S_F_LT;
      end
      S_F_LT: begin
        s_nxt     = addr_t'(cur.left);
        x_nxt     = cur.tag ? IDX_W'(1) : IDX_W'(0);
        t_nxt     = p_r + addr_t'(size_r);
        rd_a      = p_r + addr_t'(size_r);
        state_nxt = S_F_RT;
      end
      S_F_RT: begin
        used_nxt = (size_r >= used_r) ? '0 : used_r - size_r;
        if (x_r[0] && cur.tag) begin
          rd_a      = p_r;
          state_nxt = S_F11_TAGP;
        end else if (!x_r[0] && cur.tag) begin
          rd_a      = s_r;
          state_nxt = S_F01_S;
        end else if (x_r[0]) begin
          if (rv_r && addr_t'(rover_r) == t_r) begin
            rover_nxt = p_r[IDX_W-1:0];
          end
          rd_a      = p_r;
          state_nxt = S_F10_TAGP;
        end else begin
          if (rv_r && addr_t'(rover_r) == t_r) begin
            rover_nxt = s_r[IDX_W-1:0];
          end
          rd_a      = t_r;
          state_nxt = S_F00_TS;
        end
      end

      // No free neighbour: insert in front of the rover.
      S_F11_TAGP: begin
        wr_en     = !oob_r;
        w.tag     = 1'b0;
        rd_a      = f_r;
        state_nxt = S_F11_F;
      end
      S_F11_F: begin
        wr_en  = !oob_r;
        w.tag  = 1'b0;
        w.left = p_r[IDX_W-1:0];
        if (!rv_r) begin
          rd_a      = p_r;
          state_nxt = S_F11_SELF;
        end else begin
          rd_a      = addr_t'(rover_r);
          state_nxt = S_F11_Q;
        end
      end
      S_F11_SELF: begin
        wr_en     = !oob_r;
        w.left    = p_r[IDX_W-1:0];
        w.right   = p_r[IDX_W-1:0];
        rover_nxt = p_r[IDX_W-1:0];
        rv_nxt    = 1'b1;
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_F11_Q: begin
        x_nxt     = cur.left;
        rd_a      = p_r;
        state_nxt = S_F11_PL;
      end
      S_F11_PL: begin
        wr_en     = !oob_r;
        w.right   = rover_r;
        w.left    = x_r;
        rd_a      = addr_t'(rover_r);
        state_nxt = S_F11_RL;
      end
      S_F11_RL: begin
        wr_en     = !oob_r;
        w.left    = p_r[IDX_W-1:0];
        rd_a      = addr_t'(x_r);
        state_nxt = S_F11_QR;
      end
      S_F11_QR: begin
        wr_en     = !oob_r;
        w.right   = p_r[IDX_W-1:0];
        rover_nxt = p_r[IDX_W-1:0];
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end

      // Free left neighbour only: grow it.
      S_F01_S: begin
        wr_en     = !oob_r;
        w.size    = cur.size + size_r;
        rd_a      = p_r + addr_t'(size_r) - addr_t'(1);
        state_nxt = S_F01_F;
      end
      S_F01_F: begin
        wr_en     = !oob_r;
        w.left    = s_r[IDX_W-1:0];
        w.tag     = 1'b0;
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end

      // Free right neighbour only: take its place in the list.
      S_F10_TAGP: begin
        wr_en     = !oob_r;
        w.tag     = 1'b0;
        rd_a      = t_r;
        state_nxt = S_F10_A;
      end
      S_F10_A: begin
        x_nxt     = cur.left;
        rd_a      = p_r;
        state_nxt = S_F10_B;
      end
      S_F10_B: begin
        wr_en     = !oob_r;
        w.left    = x_r;
        rd_a      = t_r;
        state_nxt = S_F10_C;
      end
      S_F10_C: begin
        rd_a      = addr_t'(cur.left);
        state_nxt = S_F10_D;
      end
      S_F10_D: begin
        wr_en     = !oob_r;
        w.right   = p_r[IDX_W-1:0];
        rd_a      = t_r;
        state_nxt = S_F10_E;
      end
      S_F10_E: begin
        y_nxt     = cur.right;
        rd_a      = p_r;
        state_nxt = S_F10_F;
      end
      S_F10_F: begin
        wr_en     = !oob_r;
        w.right   = y_r;
        rd_a      = t_r;
        state_nxt = S_F10_G;
      end
      S_F10_G: begin
        rd_a      = addr_t'(cur.right);
        state_nxt = S_F10_H;
      end
      S_F10_H: begin
        wr_en     = !oob_r;
        w.left    = p_r[IDX_W-1:0];
        rd_a      = t_r;
        state_nxt = S_F10_I;
      end
      S_F10_I: begin
        sz_nxt    = cur.size;
        rd_a      = p_r;
        state_nxt = S_F10_J;
      end
      S_F10_J: begin
        wr_en     = !oob_r;
        w.size    = cur.size + sz_r;
        rd_a      = t_r;
        state_nxt = S_F10_K;
      end
      S_F10_K: begin
        rd_a      = t_r + addr_t'(cur.size) - addr_t'(1);
        state_nxt = S_F10_L;
      end
      S_F10_L: begin
        wr_en     = !oob_r;
        w.left    = p_r[IDX_W-1:0];
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end

      // Both neighbours free: fold all three into the left block.
      S_F00_TS: begin
        sz_nxt    = cur.size;
        rd_a      = s_r;
        state_nxt = S_F00_S;
      end
      S_F00_S: begin
        wr_en     = !oob_r;
        w.size    = cur.size + size_r + sz_r;
        rd_a      = t_r;
        state_nxt = S_F00_A;
      end
      S_F00_A: begin
        y_nxt     = cur.right;
        rd_a      = addr_t'(cur.left);
        state_nxt = S_F00_B;
      end
      S_F00_B: begin
        wr_en     = !oob_r;
        w.right   = y_r;
        rd_a      = t_r;
        state_nxt = S_F00_C;
      end
      S_F00_C: begin
        x_nxt     = cur.left;
        rd_a      = addr_t'(cur.right);
        state_nxt = S_F00_D;
      end
      S_F00_D: begin
        wr_en     = !oob_r;
        w.left    = x_r;
        rd_a      = t_r;
        state_nxt = S_F00_E;
      end
      S_F00_E: begin
        rd_a      = t_r + addr_t'(cur.size) - addr_t'(1);
        state_nxt = S_F00_F;
      end
      S_F00_F: begin
        wr_en     = !oob_r;
        w.left    = s_r[IDX_W-1:0];
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    wr_data = w;
    ma_nxt  = rd_a;

    // A heap size write reformats the heap.
    if (cfg_we) begin
      limit_nxt = cfg_limit;
      state_nxt = S_FMT_CLR;
      clr_nxt   = '0;
      rover_nxt = '0;
      rv_nxt    = 1'b1;
      used_nxt  = '0;
      peak_nxt  = '0;
    end

    // Result register.
    out_valid_nxt = emit;
    out_res_nxt   = out_res_r;
    if (emit) begin
      out_res_nxt.status          = emit_status;
      out_res_nxt.granted_address = emit_granted;
      out_res_nxt.in_use_units    = used_nxt;
      out_res_nxt.peak_units      = peak_nxt;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FMT_CLR;
      clr_r       <= '0;
      limit_r     <= CNT_W'(HEAP_UNITS);
      rover_r     <= '0;
      rv_r        <= 1'b1;
      used_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      limit_r     <= limit_nxt;
      rover_r     <= rover_nxt;
      rv_r        <= rv_nxt;
      used_r      <= used_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_r       <= wr_en && (wr_addr == rd_a[IDX_W-1:0]);
    end
  end

  // Working registers and the read-address bookkeeping.
  always_ff @(posedge clk) begin
    ma_r      <= ma_nxt;
    oob_r     <= rd_a >= addr_t'(limit_r);
    fwd_q_r   <= wr_data;
    p_r       <= p_nxt;
    f_r       <= f_nxt;
    s_r       <= s_nxt;
    t_r       <= t_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    size_r    <= size_nxt;
    sz_r      <= sz_nxt;
    units_r   <= units_nxt;
    n_r       <= n_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import bthau_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int CNT_SAT     = 2047;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  bthau_req_t       in_req;
  logic             out_valid;
  bthau_res_t       out_res;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  boundary_tag_heap_allocator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the heap store and allocator bookkeeping.
  int unsigned hp_tag   [HEAP_UNITS];
  int unsigned hp_size  [HEAP_UNITS];
  int unsigned hp_left  [HEAP_UNITS];
  int unsigned hp_right [HEAP_UNITS];
  int unsigned hp_limit;
  int unsigned rover;
  bit          rover_ok;
  int unsigned used_units;
  int unsigned used_max;

  bthau_res_t  pending_results[$];
  int unsigned live_blocks[$];
  int          error_count;
  int          request_count;
  int          result_count;
  int          alloc_count;
  int          free_count;
  int          idle_cycles;

  // Store accessors: anything outside the heap reads as an allocated tag.
  function automatic int unsigned rd_tag(int unsigned i);
    return (i < hp_limit) ? hp_tag[i] : 1;
  endfunction
  function automatic int unsigned rd_size(int unsigned i);
    return (i < hp_limit) ? hp_size[i] : 0;
  endfunction
  function automatic int unsigned rd_left(int unsigned i);
    return (i < hp_limit) ? hp_left[i] : 0;
  endfunction
  function automatic int unsigned rd_right(int unsigned i);
    return (i < hp_limit) ? hp_right[i] : 0;
  endfunction
  function automatic void wr_tag(int unsigned i, int unsigned v);
    if (i < hp_limit) hp_tag[i] = v & 1;
  endfunction
  function automatic void wr_size(int unsigned i, int unsigned v);
    if (i < hp_limit) hp_size[i] = v;
  endfunction
  function automatic void wr_left(int unsigned i, int unsigned v);
    if (i < hp_limit) hp_left[i] = v;
  endfunction
  function automatic void wr_right(int unsigned i, int unsigned v);
    if (i < hp_limit) hp_right[i] = v;
  endfunction
  function automatic int unsigned foot_at(int unsigned p);
    return p + rd_size(p) - 1;
  endfunction

  // Format: one free block plus an allocated sentinel in the last granule.
  function automatic void heap_format(int unsigned units_req);
    int unsigned u;
    u = units_req & 32'h7FF;
    if (u < MIN_UNITS) u = MIN_UNITS;
    if (u > HEAP_UNITS) u = HEAP_UNITS;
    hp_limit = u;
    for (int i = 0; i < HEAP_UNITS; i++) begin
      hp_tag[i] = 0; hp_size[i] = 0; hp_left[i] = 0; hp_right[i] = 0;
    end
    wr_tag(0, 0); wr_size(0, u - 1); wr_left(0, 0); wr_right(0, 0);
    wr_tag(u - 2, 0); wr_left(u - 2, 0);
    wr_tag(u - 1, 1);
    rover = 0;
    rover_ok = 1;
    used_units = 0;
    used_max = 0;
    live_blocks.delete();
  endfunction

  // Next-fit allocation from the rover; upper part is cut off when splitting.
  function automatic logic [1:0] heap_alloc(int unsigned nbytes, output int unsigned grant);
    int unsigned units, p, f, n;
    grant = 0;
    units = (nbytes + GRANULE_BYTES - 1) / GRANULE_BYTES + 2;
    n = 0;
    if (!rover_ok) return ST_NO_MEM;
    p = rover;
    while (rd_size(p) < units && rd_right(p) != rover && n < hp_limit) begin
      p = rd_right(p);
      n++;
    end
    if (rd_size(p) < units) return ST_NO_MEM;
    f = foot_at(p);
    rover = rd_right(p);
    if (rd_size(p) - units <= 1) begin
      if (rover == p) begin
        rover_ok = 0;
      end else begin
        wr_left(rover, rd_left(p));
        wr_right(rd_left(p), rover);
      end
      wr_tag(p, 1);
      wr_tag(f, 1);
    end else begin
      wr_tag(f, 1);
      wr_size(p, rd_size(p) - units);
      f = foot_at(p);
      wr_tag(f, 0);
      wr_left(f, p);
      p = f + 1;
      wr_tag(p, 1);
      wr_size(p, units);
    end
    used_units += rd_size(p);
    if (used_units > CNT_SAT) used_units = CNT_SAT;
    if (used_units > used_max) used_max = used_units;
    grant = p + 1;
    return ST_OK;
  endfunction

  // Release with coalescing against free neighbors on either side.
  function automatic void heap_release(int unsigned p);
    int unsigned sz, f, lt, rt, s, t, q;
    sz = rd_size(p);
    f  = foot_at(p);
    lt = rd_tag(p - 1);
    rt = rd_tag(p + sz);
    used_units = (sz >= used_units) ? 0 : used_units - sz;
    if (lt == 1 && rt == 1) begin
      wr_tag(p, 0);
      wr_left(f, p);
      wr_tag(f, 0);
      if (!rover_ok) begin
        wr_left(p, p);
        wr_right(p, p);
        rover = p;
        rover_ok = 1;
      end else begin
        q = rd_left(rover);
        wr_right(p, rover);
        wr_left(p, q);
        wr_left(rover, p);
        wr_right(q, p);
        rover = p;
      end
    end else if (lt == 0 && rt == 1) begin
      s = rd_left(p - 1);
      wr_size(s, rd_size(s) + sz);
      f = p + sz - 1;
      wr_left(f, s);
      wr_tag(f, 0);
    end else if (lt == 1) begin
      t = p + sz;
      if (rover_ok && rover == t) rover = p;
      wr_tag(p, 0);
      wr_left(p, rd_left(t));
      wr_right(rd_left(t), p);
      wr_right(p, rd_right(t));
      wr_left(rd_right(t), p);
      wr_size(p, rd_size(p) + rd_size(t));
      wr_left(foot_at(t), p);
    end else begin
      s = rd_left(p - 1);
      t = p + sz;
      if (rover_ok && rover == t) rover = s;
      wr_size(s, rd_size(s) + sz + rd_size(t));
      wr_right(rd_left(t), rd_right(t));
      wr_left(rd_right(t), rd_left(t));
      wr_left(foot_at(t), s);
    end
  endfunction

  // Work out the result of one accepted request.
  function automatic bthau_res_t predict_result(bthau_req_t r);
    bthau_res_t  res;
    int unsigned grant;
    res = '0;
    grant = 0;
    if (r.kind == KIND_ALLOC) begin
      res.status = heap_alloc(r.request_bytes, grant);
      if (res.status == ST_OK) live_blocks.push_back(grant);
    end else if (r.block_address == 0) begin
      res.status = ST_NULL_PTR;
    end else begin
      res.status = ST_OK;
      if (r.block_address - 1 < hp_limit) heap_release(r.block_address - 1);
    end
    res.granted_address = grant[9:0];
    res.in_use_units    = used_units[CNT_W-1:0];
    res.peak_units      = used_max[CNT_W-1:0];
    return res;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compare every result against the oldest pending prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $error("Result with no request pending: %p", out_res);
        error_count++;
      end else begin
        bthau_res_t exp_res;
        exp_res = pending_results.pop_front();
        if (out_res.status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_res.status);
          error_count++;
        end
        if (out_res.granted_address !== exp_res.granted_address) begin
          $error("granted_address: expected %0d, actual %0d",
                 exp_res.granted_address, out_res.granted_address);
          error_count++;
        end
        if (out_res.in_use_units !== exp_res.in_use_units) begin
          $error("in_use_units: expected %0d, actual %0d",
                 exp_res.in_use_units, out_res.in_use_units);
          error_count++;
        end
        if (out_res.peak_units !== exp_res.peak_units) begin
          $error("peak_units: expected %0d, actual %0d",
                 exp_res.peak_units, out_res.peak_units);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles where neither a request nor a result moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no request or result for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Send one request after a random gap; start stays high until accepted.
  task automatic send_request(bit r_kind, int unsigned nbytes, int unsigned addr);
    int unsigned gap;
    bthau_req_t  r;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    r.kind          = r_kind;
    r.request_bytes = nbytes[13:0];
    r.block_address = addr[9:0];
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_result(r));
    request_count++;
    if (r_kind == KIND_ALLOC) alloc_count++;
    else free_count++;
  endtask

  task automatic alloc_req(int unsigned nbytes);
    send_request(KIND_ALLOC, nbytes, $urandom_range(0, 1023));
  endtask

  task automatic free_req(int unsigned addr);
    send_request(KIND_FREE, $urandom_range(0, 16383), addr);
  endtask

  // Free a random live block.
  task automatic free_live();
    int idx;
    int unsigned a;
    idx = $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[idx];
    live_blocks.delete(idx);
    free_req(a);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Rewrite heap_units once the block is idle; this reformats the heap.
  task automatic set_heap_units(int unsigned units);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= units[CNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    heap_format(units);
    @(posedge clk);
  endtask

  // Directed: size extremes, null and out-of-heap frees, merges with neither or both neighbours free.
  task automatic test_directed();
    int unsigned a, b, c, d;
    alloc_req(0);
    alloc_req(16383);
    alloc_req(1);
    free_req(0);
    a = live_blocks[0];
    b = live_blocks[1];
    alloc_req(40);
    alloc_req(100);
    c = live_blocks[2];
    d = live_blocks[3];
    free_req(a);
    free_req(c);
    free_req(b);
    free_req(d);
    live_blocks.delete();
    alloc_req(15000);
    // Smallest heap: one request empties the free list.
    set_heap_units(0);
    alloc_req(16);
    alloc_req(0);
    free_live();
    alloc_req(0);
    free_live();
    // Frees whose header is past the end of a small heap are ignored.
    set_heap_units(64);
    free_req(1023);
    free_req(512);
    alloc_req(16383);
    alloc_req(800);
  endtask

  // Random traffic for one heap size, biased toward valid alloc/free pairs.
  task automatic test_random_heap(int unsigned units, int n);
    int unsigned pick;
    set_heap_units(units);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        free_req(0);
      end else if (pick < 50 || live_blocks.size() == 0) begin
        if ($urandom_range(0, 19) == 0) alloc_req($urandom_range(0, 16383));
        else if ($urandom_range(0, 3) == 0) alloc_req($urandom_range(0, 1024));
        else alloc_req($urandom_range(0, 160));
      end else begin
        free_live();
      end
    end
  endtask

  // Allocates mixed with frees of arbitrary granules on a scratch heap.
  task automatic test_noise();
    set_heap_units(256);
    for (int i = 0; i < 30; i++) begin
      if ($urandom_range(0, 2) == 0) alloc_req($urandom_range(0, 300));
      else free_req($urandom_range(1, 1023));
    end
  endtask

  initial begin
    error_count   = 0;
    request_count = 0;
    result_count  = 0;
    alloc_count   = 0;
    free_count    = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    heap_format(1024);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_heap(1024, 400);
    test_random_heap(2047, 300);
    test_random_heap(5, 100);
    test_random_heap(48, 250);
    test_random_heap($urandom_range(4, 1024), 300);
    test_random_heap(200, 300);
    test_noise();
    test_random_heap(1024, 100);

    drain_results();
    $display("Covered %0d requests (%0d allocate, %0d free), %0d results checked,",
             request_count, alloc_count, free_count, result_count);
    $display("over heap sizes from the 4-granule minimum to the full store.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/bthau_pkg.sv
hw/rtl/bthau_ram.sv
hw/rtl/boundary_tag_heap_allocator_unit.sv
dv/tb.sv
